/* rtl/core/tcce_pkg.sv */
// ============================================================================
// tcce_pkg: text console cursor engine shared definitions
// Field widths, character codes, controller states and the command/status
// bundles that join the controller and the datapath.
// ============================================================================
package tcce_pkg;

    // port field widths
    localparam int ENTRY_W = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int INDEX_W = 11;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;

    // request function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    // tab stops every four columns (power of two)
    localparam int TAB_STEP = 4;

    // reset values
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
    localparam logic [ENTRY_W-1:0] CELL_RESET  = 16'h0720;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } t_state;

    // sweep counter operations
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC,
        CNT_FILL
    } t_cnt_op;

    // controller to datapath
    typedef struct packed {
        logic    put_go;
        logic    rd_go;
        t_cnt_op cnt_op;
        logic    clr_wr;
        logic    scr_step;
        logic    fill_wr;
        logic    load_put;
        logic    load_rd;
        logic    load_scr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic put_scrolls;
        logic cnt_end;
        logic move_end;
        logic out_valid;
    } t_stat;

endpackage

/* rtl/core/tcce_ctrl.sv */
// ============================================================================
// tcce_ctrl: sequencing controller
// Runs the power-up clear sweep, accepts requests, and steps the datapath
// through cell reads and the scroll copy and blank-fill sweeps.
// ============================================================================
module tcce_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_func,
    input  logic            i_out_ready,
    input  tcce_pkg::t_stat i_stat,
    output tcce_pkg::t_cmd  o_cmd,
    output logic            o_in_ready
);
    import tcce_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   fire;

    // one request at a time; result register must be free or draining
    assign in_ready   = (r_state == ST_IDLE) && (!i_stat.out_valid || i_out_ready);
    assign fire       = i_in_valid && in_ready;
    assign o_in_ready = in_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.cnt_end) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (fire) begin
                    if (i_func == FUNC_READ) begin
                        n_state = ST_READ;
                    end else if (i_stat.put_scrolls) begin
                        n_state = ST_SCROLL;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_SCROLL: begin
                if (i_stat.move_end) n_state = ST_FILL;
            end
            ST_FILL: begin
                if (i_stat.cnt_end) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.cnt_op = CNT_HOLD;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.cnt_op = CNT_INC;
            end
            ST_IDLE: begin
                if (fire) begin
                    if (i_func == FUNC_PUT) begin
                        o_cmd.put_go   = 1'b1;
                        o_cmd.load_put = !i_stat.put_scrolls;
                        if (i_stat.put_scrolls) o_cmd.cnt_op = CNT_ZERO;
                    end else begin
                        o_cmd.rd_go = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.load_rd = 1'b1;
            end
            ST_SCROLL: begin
                o_cmd.scr_step = 1'b1;
                o_cmd.cnt_op   = i_stat.move_end ? CNT_FILL : CNT_INC;
            end
            ST_FILL: begin
                o_cmd.fill_wr  = 1'b1;
                o_cmd.cnt_op   = CNT_INC;
                o_cmd.load_scr = i_stat.cnt_end;
            end
            default: begin
                o_cmd.cnt_op = CNT_HOLD;
            end
        endcase
    end

endmodule

/* rtl/core/tcce_dp.sv */
// ============================================================================
// tcce_dp: screen store, cursor and result datapath
// Holds the cell memory, cursor, color register and sweep counter, works out
// the cursor move for a character and registers each result.
// ============================================================================
module tcce_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcce_pkg::t_cmd                i_cmd,
    output tcce_pkg::t_stat               o_stat,
    input  logic                          i_cfg_we,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_cfg_data,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::INDEX_W-1:0]  i_cell_index,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tcce_pkg::ENTRY_W-1:0]  o_read_entry,
    output logic [tcce_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tcce_pkg::COL_W-1:0]    o_cursor_col,
    output logic                          o_scrolled
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLUMNS);

    localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
    localparam logic [CW-1:0]  LAST_CELL = CW'(CELLS - 1);
    localparam logic [CW-1:0]  MOVE_END  = CW'(CELLS - COLUMNS);
    localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CLW-1:0] COL_LAST  = CLW'(COLUMNS - 1);

    // state
    logic [ENTRY_W-1:0] mem [CELLS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_oor;
    logic [COLOR_W-1:0] r_color;
    logic [RW-1:0]      r_row;
    logic [CLW-1:0]     r_col;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic               r_out_valid;
    logic [ENTRY_W-1:0] r_out_entry;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic               r_out_scr;

    // cursor move
    logic           is_nl, is_tab, is_bs, is_pr;
    logic           last_row, last_col, tab_wrap, wrap;
    logic [CLW:0]   tab_sum;
    logic [RW-1:0]  n_row, wr_row;
    logic [CLW-1:0] n_col, wr_col;
    logic [AW-1:0]  put_addr;

    // memory ports
    logic               we, rd_en, in_range;
    logic [AW-1:0]      wa, ra;
    logic [ENTRY_W-1:0] wd;
    logic [CW-1:0]      cnt_m1;

    // character decode
    assign is_nl  = (i_char_code == CH_NEWLINE);
    assign is_tab = (i_char_code == CH_TAB);
    assign is_bs  = (i_char_code == CH_BACKSPACE);
    assign is_pr  = !is_nl && !is_tab && !is_bs;

    assign last_row = (r_row == ROW_LAST);
    assign last_col = (r_col == COL_LAST);

    // next tab stop: round up to the following multiple of four
    assign tab_sum  = ({1'b0, r_col} | (CLW+1)'(TAB_STEP - 1)) + (CLW+1)'(1);
    assign tab_wrap = (tab_sum >= (CLW+1)'(COLUMNS));
    assign wrap     = is_nl || (is_tab && tab_wrap) || (is_pr && last_col);

    // cursor after a put, and the cell it writes
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        wr_row = r_row;
        wr_col = r_col;
        if (wrap) begin
            n_col = '0;
            if (!last_row) n_row = r_row + RW'(1);
        end else if (is_tab) begin
            n_col = tab_sum[CLW-1:0];
        end else if (is_bs) begin
            if (r_col != '0) begin
                n_col = r_col - CLW'(1);
            end else if (r_row != '0) begin
                n_row = r_row - RW'(1);
                n_col = COL_LAST;
            end
            wr_row = n_row;
            wr_col = n_col;
        end else begin
            n_col = r_col + CLW'(1);
        end
    end

    assign put_addr = AW'(wr_row) * COLS_A + AW'(wr_col);

    // status
    assign o_stat.put_scrolls = wrap && last_row;
    assign o_stat.cnt_end     = (r_cnt == LAST_CELL);
    assign o_stat.move_end    = (r_cnt == MOVE_END);
    assign o_stat.out_valid   = r_out_valid;

    // write port select
    assign cnt_m1 = r_cnt - CW'(1);
    always_comb begin
        we = 1'b0;
        wa = r_cnt[AW-1:0];
        wd = CELL_RESET;
        if (i_cmd.clr_wr) begin
            we = 1'b1;
        end else if (i_cmd.scr_step) begin
            // copy trails the read, writing the registered cell data one row up
            we = (r_cnt != '0);
            wa = cnt_m1[AW-1:0];
            wd = r_rd_data;
        end else if (i_cmd.fill_wr) begin
            we = 1'b1;
            wd = {r_color, CH_BLANK};
        end else if (i_cmd.put_go) begin
            we = is_pr || is_bs;
            wa = put_addr;
            wd = {r_color, (is_bs ? CH_BLANK : i_char_code)};
        end
    end

    // read port select
    assign in_range = (32'(i_cell_index) < 32'(CELLS));
    assign rd_en    = (i_cmd.rd_go && in_range) || (i_cmd.scr_step && !o_stat.move_end);
    assign ra       = i_cmd.rd_go ? AW'(i_cell_index) : (r_cnt[AW-1:0] + COLS_A);

    // screen store
    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (rd_en) r_rd_data <= mem[ra];
        if (i_cmd.rd_go) r_rd_oor <= !in_range;
    end

    // sweep counter
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_ZERO: n_cnt = '0;
            CNT_INC:  n_cnt = r_cnt + CW'(1);
            CNT_FILL: n_cnt = MOVE_END;
            default:  n_cnt = r_cnt;
        endcase
    end

    // control registers: counter, cursor, color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_color <= COLOR_RESET;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.put_go) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cfg_we) r_color <= i_cfg_data;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_put || i_cmd.load_rd || i_cmd.load_scr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_put) begin
            r_out_entry <= '0;
            r_out_row   <= ROW_W'(n_row);
            r_out_col   <= COL_W'(n_col);
            r_out_scr   <= 1'b0;
        end else if (i_cmd.load_rd) begin
            r_out_entry <= r_rd_oor ? '0 : r_rd_data;
            r_out_row   <= ROW_W'(r_row);
            r_out_col   <= COL_W'(r_col);
            r_out_scr   <= 1'b0;
        end else if (i_cmd.load_scr) begin
            r_out_entry <= '0;
            r_out_row   <= ROW_W'(r_row);
            r_out_col   <= COL_W'(r_col);
            r_out_scr   <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_entry = r_out_entry;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_scrolled   = r_out_scr;

endmodule

/* rtl/core/text_console_cursor_engine_unit.sv */
// ============================================================================
// text_console_cursor_engine_unit: text-mode console with cursor
// Keeps a ROWS x COLUMNS screen of character/color cells, prints characters
// with newline, tab and backspace handling, scrolls, and reads back cells.
// ============================================================================
// A put is answered in the cycle after acceptance; a read passes the registered
//   cell memory read, then the result register. A put that scrolls walks the
//   cell memory one cell per cycle before its result appears; no request is
//   taken then. Throughput: one put per cycle when results drain and no put
//   scrolls; a read holds off the next request until its result is loaded.
// Reset: synchronous, active low; afterwards a clear pass writes every cell to
//   grey blank with o_in_ready low.
// ============================================================================
module text_console_cursor_engine_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcce_pkg::COLOR_W-1:0]  i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::INDEX_W-1:0]  i_cell_index,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcce_pkg::ENTRY_W-1:0]  o_read_entry,
    output logic [tcce_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tcce_pkg::COL_W-1:0]    o_cursor_col,
    output logic                          o_scrolled
);
    import tcce_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // color register takes writes at any time
    assign o_cfg_ready = 1'b1;

    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready)
    );

    tcce_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_read_entry (o_read_entry),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled)
    );

endmodule

/* rtl/core/tcce_chk.sv */
// ============================================================================
// tcce_chk: port-level checks for the console engine
// Watches the top-level ports for cursor range, scroll results and a stable
// pending result.
// ============================================================================
module tcce_chk #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [tcce_pkg::ENTRY_W-1:0]  o_read_entry,
    input logic [tcce_pkg::ROW_W-1:0]    o_cursor_row,
    input logic [tcce_pkg::COL_W-1:0]    o_cursor_col,
    input logic                          o_scrolled
);
    import tcce_pkg::*;

    // cursor stays on the screen
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_row) < ROWS))
        else $error("cursor row beyond last row");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_col) < COLUMNS))
        else $error("cursor column beyond last column");

    // a scroll leaves the cursor at the start of the bottom row
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |->
            (o_cursor_row == ROW_W'(ROWS - 1)) && (o_cursor_col == '0))
        else $error("scroll result with cursor off the bottom row start");

    // only reads carry cell data, and reads never scroll
    a_scroll_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (o_read_entry == '0))
        else $error("scroll result carries cell data");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_entry) && $stable(o_cursor_row)
             && $stable(o_cursor_col) && $stable(o_scrolled)))
        else $error("pending result dropped or changed");

endmodule

bind text_console_cursor_engine_unit tcce_chk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_entry (o_read_entry),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col),
    .o_scrolled   (o_scrolled)
);
